@@ src/med3_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// med3_pkg
// Shared sizes, types and register codes of the 3x3 median stream filter.
// ----------------------------------------------------------------------------
package med3_pkg;

    localparam int MAX_WIDTH  = 128;
    localparam int MAX_HEIGHT = 128;

    localparam int PIX_W  = 8;
    localparam int DIM_W  = 8;                     // width of the size registers
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int POS_W  = 7;                     // reported row / column width

    localparam int WIN_N   = 9;
    localparam int MED_IDX = 4;
    localparam int CELL_N  = 5;                    // two sort layers per cell

    localparam int FQ_DEPTH = 16;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int CNT_W    = $clog2(FQ_DEPTH + 1);

    localparam int LB_W = 2 * PIX_W;               // {older, newer} line pair

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    typedef logic [PIX_W-1:0] t_pix;
    typedef t_pix t_win [WIN_N];

    // Results of one input: bit 0 center of window, bit 1 right border, bit 2 last row
    typedef struct packed {
        t_pix             wc4;
        t_pix             mid;
        t_pix             px;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             med;
        logic [2:0]       emit;
    } t_bnd;

    typedef struct packed {
        t_pix             v0;
        t_pix             mid;
        t_pix             px;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic [2:0]       emit;
    } t_ent;

endpackage
`default_nettype wire

@@ src/median_filter_3x3_stream.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// median_filter_3x3_stream
// 3x3 median filter over a raster pixel stream; border pixels pass unchanged.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake               | payload
//  ----------+-----+-------------------------+--------------------------------
//  s_axis    | in  | tvalid / tready         | tdata: pixel; tuser: frame_start
//  m_axis    | out | tvalid / tready         | tdata: pixel, row, col; tlast
//  cfg       | in  | valid / ready (ready=1) | index: register; data: value
//
//  One input beat per clock while input ready is high; each gives zero to three
//  result beats, one per clock while the output is ready. Results pass through
//  the address stage and line-buffer read, five sort cells and the result queue.
//  Input ready drops while sixteen accepted beats are in the chain or queued.
//  Reset (synchronous, active low) sets width and height to 128 and the
//  position to (0,0); the line buffers hold no reset value.
// ----------------------------------------------------------------------------
module median_filter_3x3_stream (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [7:0]  i_s_axis_tdata,   // [7:0] pixel
    input  wire logic        i_s_axis_tuser,   // [0] frame_start
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [23:0]      o_m_axis_tdata,   // [7:0] out_pixel, [14:8] out_row,
                                               // [21:15] out_col, [23:22] zero
    output logic             o_m_axis_tlast,   // last_of_run
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [7:0]  i_cfg_data
);

    import med3_pkg::*;

    // configuration
    logic [DIM_W-1:0] r_img_w;
    logic [DIM_W-1:0] r_img_h;
    logic [DIM_W-1:0] s_w;
    logic [DIM_W-1:0] s_h;

    // position and address stage
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [DIM_W-1:0] s_cpre, s_rpre, s_cinc, s_rinc;
    logic [COL_W-1:0] s_acol;
    logic [ROW_W-1:0] s_arow;
    logic             s_acc;
    logic             r_a_vld;
    t_pix             r_a_px;
    logic [COL_W-1:0] r_a_col;
    logic [ROW_W-1:0] r_a_row;
    logic             r_a_med;
    logic [2:0]       r_a_emit;
    logic             s_med;
    logic [2:0]       s_emit;

    // line buffers and window
    logic [LB_W-1:0]  s_lb_rd;
    logic             r_byp;
    t_pix             r_byp_top;
    t_pix             r_byp_mid;
    t_pix             s_top;
    t_pix             s_mid;
    t_pix             r_wc [6];
    t_win             s_win;
    t_bnd             s_bnd;

    // sort chain
    logic             c_vld [CELL_N+1];
    t_pix             c_win [CELL_N+1][WIN_N];
    t_bnd             c_bnd [CELL_N+1];
    t_ent             s_ent;
    logic             s_push;
    logic             s_drop;
    logic             s_retire;

    logic [CNT_W-1:0] r_cnt;
    logic [PIX_W-1:0] s_opix;
    logic [POS_W-1:0] s_orow;
    logic [POS_W-1:0] s_ocol;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= DIM_W'(MAX_WIDTH);
            r_img_h <= DIM_W'(MAX_HEIGHT);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WIDTH:  r_img_w <= i_cfg_data;
                CFG_HEIGHT: r_img_h <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    assign s_w = (r_img_w < DIM_W'(3)) ? DIM_W'(3) :
                 (r_img_w > DIM_W'(MAX_WIDTH)) ? DIM_W'(MAX_WIDTH) : r_img_w;
    assign s_h = (r_img_h < DIM_W'(3)) ? DIM_W'(3) :
                 (r_img_h > DIM_W'(MAX_HEIGHT)) ? DIM_W'(MAX_HEIGHT) : r_img_h;

    assign o_s_axis_tready = (r_cnt < CNT_W'(FQ_DEPTH));
    assign s_acc           = i_s_axis_tvalid && o_s_axis_tready;

    // Wrap a stale position first, then find where the next pixel lands.
    always_comb begin
        s_cpre = i_s_axis_tuser ? '0 : DIM_W'(r_col);
        s_rpre = i_s_axis_tuser ? '0 : DIM_W'(r_row);
        if (s_cpre >= s_w) begin
            s_cpre = '0;
            s_rpre = s_rpre + 1'b1;
        end
        if (s_rpre >= s_h) begin
            s_rpre = '0;
        end
        s_acol = s_cpre[COL_W-1:0];
        s_arow = s_rpre[ROW_W-1:0];

        s_cinc = DIM_W'(s_acol) + 1'b1;
        s_rinc = DIM_W'(s_arow) + 1'b1;
        if (s_cinc >= s_w) begin
            n_col = '0;
            n_row = (s_rinc >= s_h) ? '0 : s_rinc[ROW_W-1:0];
        end else begin
            n_col = s_cinc[COL_W-1:0];
            n_row = s_arow;
        end

        s_med     = (s_arow >= ROW_W'(2)) && (s_acol >= COL_W'(2));
        s_emit[0] = (s_arow != '0) && (s_acol != '0);
        s_emit[1] = (s_arow != '0) && (DIM_W'(s_acol) == s_w - 1'b1);
        s_emit[2] = (DIM_W'(s_arow) == s_h - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_a_vld <= 1'b0;
            r_byp   <= 1'b0;
        end else begin
            r_a_vld <= s_acc;
            if (s_acc) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            // Forward the write that lands on the address read this cycle.
            r_byp <= s_acc && r_a_vld && (s_acol == r_a_col);
        end
        r_byp_top <= s_mid;
        r_byp_mid <= r_a_px;
        if (s_acc) begin
            r_a_px   <= i_s_axis_tdata[PIX_W-1:0];
            r_a_col  <= s_acol;
            r_a_row  <= s_arow;
            r_a_med  <= s_med;
            r_a_emit <= s_emit;
        end
    end

    med3_ram #(
        .WIDTH (LB_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk   (i_clk),
        .i_we    (r_a_vld),
        .i_waddr (r_a_col),
        .i_wdata ({s_mid, r_a_px}),
        .i_re    (s_acc),
        .i_raddr (s_acol),
        .o_rdata (s_lb_rd)
    );

    assign s_top = r_byp ? r_byp_top : s_lb_rd[LB_W-1:PIX_W];
    assign s_mid = r_byp ? r_byp_mid : s_lb_rd[PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_wc[k] <= '0;
            end
        end else if (r_a_vld) begin
            r_wc[0] <= r_wc[3];
            r_wc[1] <= r_wc[4];
            r_wc[2] <= r_wc[5];
            r_wc[3] <= s_top;
            r_wc[4] <= s_mid;
            r_wc[5] <= r_a_px;
        end
    end

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            s_win[k] = r_wc[k];
        end
        s_win[6] = s_top;
        s_win[7] = s_mid;
        s_win[8] = r_a_px;
        s_bnd.wc4  = r_wc[4];
        s_bnd.mid  = s_mid;
        s_bnd.px   = r_a_px;
        s_bnd.row  = r_a_row;
        s_bnd.col  = r_a_col;
        s_bnd.med  = r_a_med;
        s_bnd.emit = r_a_emit;
    end

    assign c_vld[0] = r_a_vld;
    assign c_win[0] = s_win;
    assign c_bnd[0] = s_bnd;

    for (genvar g = 0; g < CELL_N; g++) begin : g_cell
        med3_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (c_vld[g]),
            .i_win   (c_win[g]),
            .i_bnd   (c_bnd[g]),
            .o_vld   (c_vld[g+1]),
            .o_win   (c_win[g+1]),
            .o_bnd   (c_bnd[g+1])
        );
    end

    always_comb begin
        s_ent.v0   = c_bnd[CELL_N].med ? c_win[CELL_N][MED_IDX] : c_bnd[CELL_N].wc4;
        s_ent.mid  = c_bnd[CELL_N].mid;
        s_ent.px   = c_bnd[CELL_N].px;
        s_ent.row  = c_bnd[CELL_N].row;
        s_ent.col  = c_bnd[CELL_N].col;
        s_ent.emit = c_bnd[CELL_N].emit;
    end

    assign s_push = c_vld[CELL_N] && (c_bnd[CELL_N].emit != 3'b000);
    assign s_drop = c_vld[CELL_N] && (c_bnd[CELL_N].emit == 3'b000);

    // Count beats accepted whose results are not yet all sent.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= r_cnt + CNT_W'(s_acc) - CNT_W'(s_drop) - CNT_W'(s_retire);
        end
    end

    med3_outq u_outq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (s_push),
        .i_ent    (s_ent),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_pix    (s_opix),
        .o_row    (s_orow),
        .o_col    (s_ocol),
        .o_last   (o_m_axis_tlast),
        .o_retire (s_retire)
    );

    assign o_m_axis_tdata = {2'b00, s_ocol, s_orow, s_opix};

endmodule
`default_nettype wire

@@ src/med3_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// med3_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module med3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ src/med3_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// med3_cell
// One sort cell: an even and an odd compare-exchange layer over the nine
// window values, registered; the result bundle rides along.
// ----------------------------------------------------------------------------
module med3_cell (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_vld,
    input  wire med3_pkg::t_pix i_win [med3_pkg::WIN_N],
    input  wire med3_pkg::t_bnd i_bnd,
    output logic               o_vld,
    output med3_pkg::t_pix     o_win [med3_pkg::WIN_N],
    output med3_pkg::t_bnd     o_bnd
);

    import med3_pkg::*;

    t_pix s_even [WIN_N];
    t_pix s_odd  [WIN_N];
    t_pix r_win  [WIN_N];
    t_bnd r_bnd;
    logic r_vld;

    always_comb begin
        s_even = i_win;
        for (int k = 0; k < (WIN_N - 1) / 2; k++) begin
            if (i_win[2*k] > i_win[2*k+1]) begin
                s_even[2*k]   = i_win[2*k+1];
                s_even[2*k+1] = i_win[2*k];
            end
        end
        s_odd = s_even;
        for (int k = 0; k < (WIN_N - 1) / 2; k++) begin
            if (s_even[2*k+1] > s_even[2*k+2]) begin
                s_odd[2*k+1] = s_even[2*k+2];
                s_odd[2*k+2] = s_even[2*k+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
        end
        r_win <= s_odd;
        r_bnd <= i_bnd;
    end

    assign o_vld = r_vld;
    assign o_win = r_win;
    assign o_bnd = r_bnd;

endmodule
`default_nettype wire

@@ src/med3_outq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// med3_outq
// Result queue: holds the result set of each input that yields results and hands
// its results out one beat at a time, flagging the last one of each set.
// ----------------------------------------------------------------------------
module med3_outq (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire med3_pkg::t_ent                i_ent,
    output logic                               o_tvalid,
    input  wire logic                          i_tready,
    output logic [med3_pkg::PIX_W-1:0]         o_pix,
    output logic [med3_pkg::POS_W-1:0]         o_row,
    output logic [med3_pkg::POS_W-1:0]         o_col,
    output logic                               o_last,
    output logic                               o_retire
);

    import med3_pkg::*;

    t_ent             r_mem [FQ_DEPTH];
    logic [FQ_AW:0]   r_wp;
    logic [FQ_AW:0]   r_rp;
    logic [2:0]       r_done;
    t_ent             s_head;
    logic [2:0]       s_pend;
    logic [2:0]       s_sel;
    logic [ROW_W-1:0] s_row;
    logic [COL_W-1:0] s_col;
    logic             s_fire;

    assign s_head   = r_mem[r_wp == r_rp ? r_rp[FQ_AW-1:0] : r_rp[FQ_AW-1:0]];
    assign s_pend   = s_head.emit & ~r_done;
    assign o_tvalid = (r_wp != r_rp);
    assign s_fire   = o_tvalid && i_tready;

    always_comb begin
        s_sel  = 3'b000;
        o_pix  = s_head.px;
        s_row  = s_head.row;
        s_col  = s_head.col;
        o_last = 1'b1;
        if (s_pend[0]) begin
            s_sel  = 3'b001;
            o_pix  = s_head.v0;
            s_row  = s_head.row - 1'b1;
            s_col  = s_head.col - 1'b1;
            o_last = !s_pend[1] && !s_pend[2];
        end else if (s_pend[1]) begin
            s_sel  = 3'b010;
            o_pix  = s_head.mid;
            s_row  = s_head.row - 1'b1;
            o_last = !s_pend[2];
        end else begin
            s_sel  = 3'b100;
        end
    end

    assign o_row    = s_row[POS_W-1:0];
    assign o_col    = s_col[POS_W-1:0];
    assign o_retire = s_fire && o_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_done <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (s_fire) begin
                if (o_last) begin
                    r_rp   <= r_rp + 1'b1;
                    r_done <= '0;
                end else begin
                    r_done <= r_done | s_sel;
                end
            end
        end
        if (i_push) begin
            r_mem[r_wp[FQ_AW-1:0]] <= i_ent;
        end
    end

endmodule
`default_nettype wire
